// File: src/ptns_pkg.sv
// Shared codes and types for the point table nearest search block.
// No dependencies; used by ptns_dist and point_table_nearest_search_top.
package ptns_pkg;

   // operation codes
   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_FREE  = 3'd1;
   localparam logic [2:0] OP_FIND  = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NONE = 2'd2;

   // a distance must be strictly below this to match
   localparam logic [31:0] DIST_LIMIT = 32'h7FFF_FFFF;

   // candidate control from the distance pipeline
   typedef struct packed {
      logic valid;     // candidate output holds a scanned slot
      logic eligible;  // slot live and distance below the limit
      logic busy;      // earlier stages still hold slots
   } ptns_cand_type;

endpackage

// File: src/ptns_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/ptns_dist.sv
// Three-stage squared-distance pipeline: abs difference, squares, sum and limit check.
// Depends on ptns_pkg.
module ptns_dist #(
   parameter int COORD_BITS = 16,
   parameter int ID_W       = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic                         in_live,
   input  logic [ID_W-1:0]              in_idx,
   input  logic signed [COORD_BITS-1:0] in_px,
   input  logic signed [COORD_BITS-1:0] in_py,
   input  logic signed [COORD_BITS-1:0] q_x,
   input  logic signed [COORD_BITS-1:0] q_y,
   output ptns_pkg::ptns_cand_type      cand,
   output logic [2*COORD_BITS:0]        cand_d,
   output logic [ID_W-1:0]              cand_idx,
   output logic signed [COORD_BITS-1:0] cand_x,
   output logic signed [COORD_BITS-1:0] cand_y
);

   localparam int C  = COORD_BITS;
   localparam int DW = 2 * C + 1;
   localparam int EW = (DW > 32) ? DW : 32;

   logic                s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic                s3_valid_ff, s3_valid_in;
   logic                s1_live_ff, s2_live_ff, s3_elig_ff;
   logic                s1_live_in, s2_live_in, s3_elig_in;
   logic [ID_W-1:0]     s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic [ID_W-1:0]     s1_idx_in, s2_idx_in, s3_idx_in;
   logic signed [C-1:0] s1_px_ff, s1_py_ff, s2_px_ff, s2_py_ff, s3_px_ff, s3_py_ff;
   logic signed [C-1:0] s1_px_in, s1_py_in, s2_px_in, s2_py_in, s3_px_in, s3_py_in;
   logic [C-1:0]        s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;
   logic [2*C-1:0]      s2_sqx_ff, s2_sqy_ff, s2_sqx_in, s2_sqy_in;
   logic [DW-1:0]       s3_d_ff, s3_d_in;
   logic [C:0]          diff_x, diff_y, neg_x, neg_y;

   // |p - q| fits in C bits for C-bit signed operands
   always_comb begin
      diff_x    = {in_px[C-1], in_px} - {q_x[C-1], q_x};
      diff_y    = {in_py[C-1], in_py} - {q_y[C-1], q_y};
      neg_x     = -diff_x;
      neg_y     = -diff_y;
      s1_dx_in  = diff_x[C] ? neg_x[C-1:0] : diff_x[C-1:0];
      s1_dy_in  = diff_y[C] ? neg_y[C-1:0] : diff_y[C-1:0];
      s1_valid_in = in_valid;
      s1_live_in  = in_live;
      s1_idx_in   = in_idx;
      s1_px_in    = in_px;
      s1_py_in    = in_py;

      s2_valid_in = s1_valid_ff;
      s2_live_in  = s1_live_ff;
      s2_idx_in   = s1_idx_ff;
      s2_px_in    = s1_px_ff;
      s2_py_in    = s1_py_ff;
      s2_sqx_in   = (2*C)'(s1_dx_ff) * (2*C)'(s1_dx_ff);
      s2_sqy_in   = (2*C)'(s1_dy_ff) * (2*C)'(s1_dy_ff);

      s3_valid_in = s2_valid_ff;
      s3_idx_in   = s2_idx_ff;
      s3_px_in    = s2_px_ff;
      s3_py_in    = s2_py_ff;
      s3_d_in     = DW'(s2_sqx_ff) + DW'(s2_sqy_ff);
      s3_elig_in  = s2_live_ff && (EW'(s3_d_in) < EW'(ptns_pkg::DIST_LIMIT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_live_ff <= s1_live_in;
      s1_idx_ff  <= s1_idx_in;
      s1_px_ff   <= s1_px_in;
      s1_py_ff   <= s1_py_in;
      s1_dx_ff   <= s1_dx_in;
      s1_dy_ff   <= s1_dy_in;
      s2_live_ff <= s2_live_in;
      s2_idx_ff  <= s2_idx_in;
      s2_px_ff   <= s2_px_in;
      s2_py_ff   <= s2_py_in;
      s2_sqx_ff  <= s2_sqx_in;
      s2_sqy_ff  <= s2_sqy_in;
      s3_elig_ff <= s3_elig_in;
      s3_idx_ff  <= s3_idx_in;
      s3_px_ff   <= s3_px_in;
      s3_py_ff   <= s3_py_in;
      s3_d_ff    <= s3_d_in;
   end

   assign cand.valid    = s3_valid_ff;
   assign cand.eligible = s3_elig_ff;
   assign cand.busy     = s1_valid_ff | s2_valid_ff;
   assign cand_d        = s3_d_ff;
   assign cand_idx      = s3_idx_ff;
   assign cand_x        = s3_px_ff;
   assign cand_y        = s3_py_ff;

endmodule

// File: src/point_table_nearest_search_top.sv
// Top level of the point table with nearest-point search.
// Depends on ptns_pkg, ptns_ram and ptns_dist.
//
// The table holds SLOTS 2-D points in one slot RAM whose word is
// {live, free link, x, y}. One item is handled at a time. Add and free do
// one RAM read, then the write-back, and read does only the RAM read; add
// into a never-used slot, clear and unknown operations need no RAM read.
// For find, the single RAM read port visits one slot per cycle up to the
// high-water mark, followed by the drain of the three-stage distance
// pipeline. Results sit in an output register, so a stalled result does
// not keep the next item from being accepted, though that item's result
// waits for the register to empty. The high-water mark serves as fill
// count for the live bits: slots at or above it read as empty, so reset
// and clear need no sweep of the RAM and are instant. Coordinates of a
// slot never added are undefined but never reach a result.
module point_table_nearest_search_top #(
   parameter int SLOTS      = 1024,
   parameter int COORD_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_operation,
   input  logic [$clog2(SLOTS)-1:0]             req_slot_id,
   input  logic signed [COORD_BITS-1:0]         req_pos_x,
   input  logic signed [COORD_BITS-1:0]         req_pos_y,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [$clog2(SLOTS)-1:0]             rsp_result_id,
   output logic [1:0]                           rsp_status,
   output logic signed [COORD_BITS-1:0]         rsp_out_x,
   output logic signed [COORD_BITS-1:0]         rsp_out_y,
   output logic [$clog2(SLOTS+1)-1:0]           rsp_live_count
);

   localparam int C      = COORD_BITS;
   localparam int ID_W   = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int DW     = 2 * C + 1;
   localparam int WORD_W = 1 + CNT_W + 2 * C;
   localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(SLOTS);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ADD  = 3'd1;
   localparam logic [2:0] S_FREE = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_SCAN = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    hw_ff, hw_in, head_ff, head_in, live_ff, live_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic [ID_W-1:0]     sid_ff, sid_in;
   logic signed [C-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic                rdv_ff, rdv_in;
   logic [ID_W-1:0]     rdidx_ff, rdidx_in;
   logic                found_ff, found_in;
   logic [DW-1:0]       best_d_ff, best_d_in;
   logic [ID_W-1:0]     best_id_ff, best_id_in;
   logic signed [C-1:0] best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic [ID_W-1:0]     res_id_ff, res_id_in;
   logic [1:0]          res_st_ff, res_st_in;
   logic signed [C-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [1:0]          rsp_st_ff, rsp_st_in;
   logic signed [C-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [CNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;

   // slot RAM port
   logic                ram_we;
   logic [ID_W-1:0]     ram_waddr, ram_raddr;
   logic [WORD_W-1:0]   ram_wdata, ram_rdata;
   logic                rd_live;
   logic [CNT_W-1:0]    rd_link;
   logic signed [C-1:0] rd_x, rd_y;

   // distance pipeline output
   ptns_pkg::ptns_cand_type cand;
   logic [DW-1:0]       cand_d;
   logic [ID_W-1:0]     cand_idx;
   logic signed [C-1:0] cand_x, cand_y;

   logic                accept, slot_ok, scan_end;

   assign rd_y    = ram_rdata[C-1:0];
   assign rd_x    = ram_rdata[2*C-1:C];
   assign rd_link = ram_rdata[2*C+CNT_W-1:2*C];
   assign rd_live = ram_rdata[WORD_W-1];

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   // the live bit is trusted only below the high-water mark
   assign slot_ok   = (CNT_W'(sid_ff) < hw_ff) && rd_live;
   assign scan_end  = (scan_ff == hw_ff) && !rdv_ff && !cand.busy && !cand.valid;

   ptns_ram #(
      .WIDTH(WORD_W),
      .DEPTH(SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ptns_dist #(
      .COORD_BITS(COORD_BITS),
      .ID_W      (ID_W)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rdv_ff),
      .in_live  (rd_live),
      .in_idx   (rdidx_ff),
      .in_px    (rd_x),
      .in_py    (rd_y),
      .q_x      (qx_ff),
      .q_y      (qy_ff),
      .cand     (cand),
      .cand_d   (cand_d),
      .cand_idx (cand_idx),
      .cand_x   (cand_x),
      .cand_y   (cand_y)
   );

   always_comb begin
      state_in   = state_ff;
      hw_in      = hw_ff;
      head_in    = head_ff;
      live_in    = live_ff;
      scan_in    = scan_ff;
      sid_in     = sid_ff;
      qx_in      = qx_ff;
      qy_in      = qy_ff;
      rdv_in     = 1'b0;
      rdidx_in   = rdidx_ff;
      found_in   = found_ff;
      best_d_in  = best_d_ff;
      best_id_in = best_id_ff;
      best_x_in  = best_x_ff;
      best_y_in  = best_y_ff;
      res_id_in  = res_id_ff;
      res_st_in  = res_st_ff;
      res_x_in   = res_x_ff;
      res_y_in   = res_y_ff;
      ram_we     = 1'b0;
      ram_waddr  = sid_ff;
      ram_wdata  = ram_rdata;
      ram_raddr  = sid_ff;

      // output register empties when taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_id_in    = rsp_id_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      // running minimum; strict compare keeps the lowest slot on ties
      if (cand.valid && cand.eligible && (!found_ff || (cand_d < best_d_ff))) begin
         found_in   = 1'b1;
         best_d_in  = cand_d;
         best_id_in = cand_idx;
         best_x_in  = cand_x;
         best_y_in  = cand_y;
      end

      case (state_ff)
         S_IDLE: begin
            // add reads the free-list head, free and read read the slot
            ram_raddr = (req_operation == ptns_pkg::OP_ADD) ? head_ff[ID_W-1:0]
                                                            : req_slot_id;
            if (accept) begin
               sid_in    = req_slot_id;
               qx_in     = req_pos_x;
               qy_in     = req_pos_y;
               res_id_in = '0;
               res_st_in = ptns_pkg::ST_OK;
               res_x_in  = '0;
               res_y_in  = '0;
               case (req_operation)
                  ptns_pkg::OP_ADD: begin
                     if (head_ff != NULL_LINK) begin
                        state_in = S_ADD;
                     end else if (hw_ff != NULL_LINK) begin
                        // fresh slot at the high-water mark
                        ram_we    = 1'b1;
                        ram_waddr = hw_ff[ID_W-1:0];
                        ram_wdata = {1'b1, NULL_LINK, req_pos_x, req_pos_y};
                        res_id_in = hw_ff[ID_W-1:0];
                        hw_in     = hw_ff + CNT_W'(1);
                        live_in   = live_ff + CNT_W'(1);
                        state_in  = S_DONE;
                     end else begin
                        res_st_in = ptns_pkg::ST_FULL;
                        state_in  = S_DONE;
                     end
                  end
                  ptns_pkg::OP_FREE: begin
                     state_in = S_FREE;
                  end
                  ptns_pkg::OP_READ: begin
                     state_in = S_READ;
                  end
                  ptns_pkg::OP_FIND: begin
                     scan_in  = '0;
                     found_in = 1'b0;
                     state_in = S_SCAN;
                  end
                  ptns_pkg::OP_CLEAR: begin
                     hw_in    = '0;
                     head_in  = NULL_LINK;
                     live_in  = '0;
                     state_in = S_DONE;
                  end
                  default: begin
                     res_st_in = ptns_pkg::ST_NONE;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end
         S_ADD: begin
            // pop the free list; read data holds the head slot's link
            ram_we    = 1'b1;
            ram_waddr = head_ff[ID_W-1:0];
            ram_wdata = {1'b1, rd_link, qx_ff, qy_ff};
            res_id_in = head_ff[ID_W-1:0];
            head_in   = rd_link;
            live_in   = live_ff + CNT_W'(1);
            state_in  = S_DONE;
         end
         S_FREE: begin
            res_id_in = sid_ff;
            if (slot_ok) begin
               ram_we    = 1'b1;
               ram_wdata = {1'b0, head_ff, rd_x, rd_y};
               head_in   = CNT_W'(sid_ff);
               live_in   = live_ff - CNT_W'(1);
            end else begin
               res_st_in = ptns_pkg::ST_NONE;
            end
            state_in = S_DONE;
         end
         S_READ: begin
            res_id_in = sid_ff;
            if (slot_ok) begin
               res_x_in = rd_x;
               res_y_in = rd_y;
            end else begin
               res_st_in = ptns_pkg::ST_NONE;
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            ram_raddr = scan_ff[ID_W-1:0];
            if (scan_ff < hw_ff) begin
               rdv_in   = 1'b1;
               rdidx_in = scan_ff[ID_W-1:0];
               scan_in  = scan_ff + CNT_W'(1);
            end
            if (scan_end) begin
               if (found_ff) begin
                  res_id_in = best_id_ff;
                  res_x_in  = best_x_ff;
                  res_y_in  = best_y_ff;
               end else begin
                  res_st_in = ptns_pkg::ST_NONE;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = res_id_ff;
               rsp_st_in    = res_st_ff;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               rsp_cnt_in   = live_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hw_ff        <= '0;
         head_ff      <= NULL_LINK;
         live_ff      <= '0;
         scan_ff      <= '0;
         rdv_ff       <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hw_ff        <= hw_in;
         head_ff      <= head_in;
         live_ff      <= live_in;
         scan_ff      <= scan_in;
         rdv_ff       <= rdv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sid_ff     <= sid_in;
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      rdidx_ff   <= rdidx_in;
      best_d_ff  <= best_d_in;
      best_id_ff <= best_id_in;
      best_x_ff  <= best_x_in;
      best_y_ff  <= best_y_in;
      res_id_ff  <= res_id_in;
      res_st_ff  <= res_st_in;
      res_x_ff   <= res_x_in;
      res_y_ff   <= res_y_in;
      rsp_id_ff  <= rsp_id_in;
      rsp_st_ff  <= rsp_st_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result_id  = rsp_id_ff;
   assign rsp_status     = rsp_st_ff;
   assign rsp_out_x      = rsp_x_ff;
   assign rsp_out_y      = rsp_y_ff;
   assign rsp_live_count = rsp_cnt_ff;

   // live slots all lie below the high-water mark
   a_live_le_hw: assert property (@(posedge clock) disable iff (reset)
      live_ff <= hw_ff)
      else $error("live count above high-water mark");

   // a non-null free-list head points at a used slot
   a_head_used: assert property (@(posedge clock) disable iff (reset)
      (head_ff != NULL_LINK) |-> (head_ff < hw_ff))
      else $error("free-list head beyond high-water mark");

   // the scan never runs past the high-water mark
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_ff <= hw_ff))
      else $error("scan index past high-water mark");

   // the RAM is never written while a find is scanning or a result waits in S_DONE
   a_no_write_scan: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff != S_SCAN && state_ff != S_DONE))
      else $error("slot RAM written outside an update step");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for point_table_nearest_search_top.
// Depends on ptns_pkg and the block's RTL; uses a behavioral point-table model
// to predict every result item.
module tb;

   localparam int SLOTS      = 1024;
   localparam int COORD_BITS = 16;
   localparam int ID_W       = 10;
   localparam int CNT_W      = 11;
   // watchdog limit on the length of the whole run
   localparam int CYCLE_LIMIT  = 1_000_000;
   // wait after the last predicted result, sized to outlast the longest find
   localparam int DRAIN_CYCLES = 1100;
   localparam int RANDOM_ITEMS = 540;

   typedef struct {
      logic [2:0]                   op;
      logic [ID_W-1:0]              slot;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      bit                           hold;   // marker: wait until all results are back
   } table_req_type;

   typedef struct {
      logic [ID_W-1:0]              id;
      logic [1:0]                   status;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [CNT_W-1:0]             count;
   } table_rsp_type;

   // ---------------------------------------------------------------------
   // DUT connections; every input starts at a known value
   // ---------------------------------------------------------------------
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [2:0]                   req_operation = '0;
   logic [ID_W-1:0]              req_slot_id = '0;
   logic signed [COORD_BITS-1:0] req_pos_x = '0;
   logic signed [COORD_BITS-1:0] req_pos_y = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [ID_W-1:0]              rsp_result_id;
   logic [1:0]                   rsp_status;
   logic signed [COORD_BITS-1:0] rsp_out_x;
   logic signed [COORD_BITS-1:0] rsp_out_y;
   logic [CNT_W-1:0]             rsp_live_count;

   point_table_nearest_search_top #(
      .SLOTS      (SLOTS),
      .COORD_BITS (COORD_BITS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_slot_id    (req_slot_id),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_result_id  (rsp_result_id),
      .rsp_status     (rsp_status),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_live_count (rsp_live_count)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Point table model: own copy of the slot store and list pointers
   // ---------------------------------------------------------------------
   logic signed [COORD_BITS-1:0] tbl_x [SLOTS];
   logic signed [COORD_BITS-1:0] tbl_y [SLOTS];
   bit                           tbl_live [SLOTS];
   int unsigned                  tbl_link [SLOTS];
   int unsigned                  tbl_free_head  = SLOTS;   // SLOTS means empty list
   int unsigned                  tbl_high_water = 0;
   int unsigned                  tbl_live_total = 0;

   table_req_type pending_reqs [$];
   table_rsp_type expected_rsps [$];

   int unsigned cycle_count    = 0;
   int unsigned mismatch_count = 0;
   int unsigned rsp_seen       = 0;

   // Apply one item to the table model and return the result item it causes.
   function automatic table_rsp_type apply_table_op(table_req_type r);
      table_rsp_type p;
      int unsigned   s;
      int            i;
      int            hit;
      longint        dx, dy, d, best;
      p.id     = '0;
      p.status = ptns_pkg::ST_OK;
      p.x      = '0;
      p.y      = '0;
      case (r.op)
         ptns_pkg::OP_ADD: begin
            // LIFO reuse first, then the next never-used slot
            if (tbl_free_head < SLOTS) begin
               s = tbl_free_head;
               tbl_free_head = tbl_link[s];
            end else if (tbl_high_water < SLOTS) begin
               s = tbl_high_water;
               tbl_high_water++;
            end else begin
               s = SLOTS;
            end
            if (s < SLOTS) begin
               tbl_x[s]    = r.x;
               tbl_y[s]    = r.y;
               tbl_live[s] = 1'b1;
               tbl_live_total++;
               p.id = s[ID_W-1:0];
            end else begin
               p.status = ptns_pkg::ST_FULL;
            end
         end
         ptns_pkg::OP_FREE: begin
            p.id = r.slot;
            if (r.slot < tbl_high_water && tbl_live[r.slot]) begin
               tbl_live[r.slot] = 1'b0;
               tbl_link[r.slot] = tbl_free_head;
               tbl_free_head    = r.slot;
               tbl_live_total--;
            end else begin
               p.status = ptns_pkg::ST_NONE;
            end
         end
         ptns_pkg::OP_FIND: begin
            // full-width squared distance; strict compare keeps the lowest slot on ties
            best = longint'(ptns_pkg::DIST_LIMIT);
            hit  = -1;
            for (i = 0; i < tbl_high_water; i++) begin
               if (tbl_live[i]) begin
                  dx = longint'(tbl_x[i]) - longint'(r.x);
                  dy = longint'(tbl_y[i]) - longint'(r.y);
                  d  = dx * dx + dy * dy;
                  if (d < best) begin
                     best = d;
                     hit  = i;
                  end
               end
            end
            if (hit >= 0) begin
               p.id = hit[ID_W-1:0];
               p.x  = tbl_x[hit];
               p.y  = tbl_y[hit];
            end else begin
               p.status = ptns_pkg::ST_NONE;
            end
         end
         ptns_pkg::OP_READ: begin
            p.id = r.slot;
            if (r.slot < tbl_high_water && tbl_live[r.slot]) begin
               p.x = tbl_x[r.slot];
               p.y = tbl_y[r.slot];
            end else begin
               p.status = ptns_pkg::ST_NONE;
            end
         end
         ptns_pkg::OP_CLEAR: begin
            for (i = 0; i < SLOTS; i++) tbl_live[i] = 1'b0;
            tbl_free_head  = SLOTS;
            tbl_high_water = 0;
            tbl_live_total = 0;
         end
         default: begin
            p.status = ptns_pkg::ST_NONE;
         end
      endcase
      p.count = tbl_live_total[CNT_W-1:0];
      return p;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic void push_item(logic [2:0] op, logic [ID_W-1:0] slot,
                                     logic signed [COORD_BITS-1:0] x,
                                     logic signed [COORD_BITS-1:0] y);
      table_req_type r;
      r.op   = op;
      r.slot = slot;
      r.x    = x;
      r.y    = y;
      r.hold = 1'b0;
      pending_reqs.push_back(r);
   endfunction

   function automatic void push_hold();
      table_req_type r;
      r.op   = ptns_pkg::OP_CLEAR;
      r.slot = '0;
      r.x    = '0;
      r.y    = '0;
      r.hold = 1'b1;
      pending_reqs.push_back(r);
   endfunction

   // style 0: full range, 1: tight cluster (ties, near hits), else: edge values
   function automatic logic signed [COORD_BITS-1:0] rand_coord(int unsigned style);
      logic [31:0] raw;
      case (style)
         0: raw = $urandom;
         1: raw = $urandom_range(0, 80) - 40;
         default: begin
            case ($urandom_range(0, 5))
               0: raw = 32'h8000;
               1: raw = 32'h8001;
               2: raw = 32'h7FFE;
               3: raw = 32'h7FFF;
               4: raw = 32'hFFFF;
               default: raw = 32'h0000;
            endcase
         end
      endcase
      return raw[COORD_BITS-1:0];
   endfunction

   // Per-item wait count, 0..18; a burst mode with no waits toggles now and then.
   function automatic int unsigned draw_wait(inout bit burst);
      if ($urandom_range(0, 29) == 0) burst = !burst;
      return burst ? 0 : $urandom_range(0, 18);
   endfunction

   task automatic report_mismatch(string field, logic signed [63:0] got,
                                  logic signed [63:0] want);
      $display("result %0d: %s is %0d, predicted %0d", rsp_seen, field, got, want);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Driver: pops pending items, waits its drawn gap before each one.
   // Hold markers park the sender until every predicted result has arrived.
   // ---------------------------------------------------------------------
   table_req_type cur_req;
   int unsigned   req_gap    = 0;
   bit            send_burst = 1'b0;

   always @(posedge clock) begin
      bit fire;
      fire = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) begin
            expected_rsps.push_back(apply_table_op(cur_req));
            req_gap = draw_wait(send_burst);
         end
         if (req_valid && !fire) begin
            // stalled: payload and valid stay as they are
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0 && pending_reqs[0].hold) begin
            if (expected_rsps.size() == 0) pending_reqs.delete(0);
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            cur_req = pending_reqs.pop_front();
            req_valid     <= 1'b1;
            req_operation <= cur_req.op;
            req_slot_id   <= cur_req.slot;
            req_pos_x     <= cur_req.x;
            req_pos_y     <= cur_req.y;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each accepted result item against the oldest prediction,
   // then stalls for a drawn number of cycles.
   // ---------------------------------------------------------------------
   int unsigned rsp_wait   = 0;
   bit          recv_burst = 1'b0;

   always @(posedge clock) begin
      table_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("unpredicted result_id", rsp_result_id, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_result_id !== want.id)
                  report_mismatch("result_id", rsp_result_id, want.id);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_out_x !== want.x)
                  report_mismatch("out_x", rsp_out_x, want.x);
               if (rsp_out_y !== want.y)
                  report_mismatch("out_y", rsp_out_y, want.y);
               if (rsp_live_count !== want.count)
                  report_mismatch("live_count", rsp_live_count, want.count);
            end
            rsp_wait = draw_wait(recv_burst);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_stall <= (rsp_wait > 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of test
   // ---------------------------------------------------------------------
   initial begin
      int unsigned n_random;
      int unsigned n_add, n_mix, span, hw_est, k, pick, style_sel, style;
      logic [2:0]  op;
      logic [ID_W-1:0] slot;

      // --- directed: empty table, LIFO reuse, ties, distance limit, bad ops
      push_item(ptns_pkg::OP_FIND,  0, 0, 0);   // find in empty table
      push_item(ptns_pkg::OP_READ,  0, 0, 0);   // read of never-used slot
      push_item(ptns_pkg::OP_FREE,  0, 0, 0);   // free at the high-water mark
      push_item(ptns_pkg::OP_ADD,   0, 16'sh8000, 16'sh8000);
      push_item(ptns_pkg::OP_ADD,   0, 16'sh7FFF, 16'sh7FFF);
      push_item(ptns_pkg::OP_ADD,   0, 0, 0);
      push_item(ptns_pkg::OP_ADD,   0, 0, 0);   // same point, higher slot
      push_item(ptns_pkg::OP_FIND,  0, 1, 1);   // tie: lowest slot wins
      push_item(ptns_pkg::OP_READ,  1, 0, 0);
      push_item(ptns_pkg::OP_FREE,  2, 0, 0);
      push_item(ptns_pkg::OP_FREE,  2, 0, 0);   // double free
      push_item(ptns_pkg::OP_FIND,  0, 0, 0);
      push_item(ptns_pkg::OP_ADD,   0, 5, -5);  // reuses freed slot
      push_item(ptns_pkg::OP_FREE,  3, 0, 0);
      push_item(ptns_pkg::OP_FREE,  0, 0, 0);
      push_item(ptns_pkg::OP_ADD,   0, 7, 7);   // last freed comes back first
      push_item(ptns_pkg::OP_ADD,   0, -7, -7);
      push_item(ptns_pkg::OP_READ,  10'h3FF, 0, 0);
      push_item(3'd5, 10'h3FF, 16'shFFFF, 16'shFFFF);   // unknown operations
      push_item(3'd6, 0, 0, 0);
      push_item(3'd7, 10'h155, 16'sh5555, 16'shAAAA);
      push_item(ptns_pkg::OP_CLEAR, 0, 0, 0);
      push_item(ptns_pkg::OP_ADD,   0, 16'sh8000, 16'sh8000);
      push_item(ptns_pkg::OP_FIND,  0, 16'sh7FFF, 16'sh7FFF);   // far beyond the limit
      push_item(ptns_pkg::OP_FIND,  0, 13572, 16'sh8000);       // dx 46340: just inside
      push_item(ptns_pkg::OP_FIND,  0, 13573, 16'sh8000);       // dx 46341: just outside

      // sender waits for every outstanding result here
      push_hold();

      // --- random episodes: mostly fill-then-exercise, some noise
      n_random = 0;
      hw_est   = 0;
      while (n_random < RANDOM_ITEMS) begin
         if (hw_est > 200 || $urandom_range(0, 3) != 0) begin
            push_item(ptns_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
            hw_est = 0;
            n_random++;
         end
         if ($urandom_range(0, 9) == 0) push_hold();
         style_sel = $urandom_range(0, 2);
         n_add = $urandom_range(1, 40);
         for (k = 0; k < n_add; k++) begin
            style = (style_sel == 1 && $urandom_range(0, 9) < 7) ? 1 :
                    ($urandom_range(0, 9) == 0 ? 2 : 0);
            push_item(ptns_pkg::OP_ADD, $urandom, rand_coord(style), rand_coord(style));
            n_random++;
         end
         hw_est += n_add;
         span = hw_est + 8;
         n_mix = $urandom_range(5, 30);
         for (k = 0; k < n_mix; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)      op = ptns_pkg::OP_ADD;
            else if (pick < 45) op = ptns_pkg::OP_FREE;
            else if (pick < 70) op = ptns_pkg::OP_FIND;
            else if (pick < 88) op = ptns_pkg::OP_READ;
            else if (pick < 92) op = ptns_pkg::OP_CLEAR;
            else                op = 3'($urandom_range(5, 7));
            slot = ($urandom_range(0, 4) != 0) ? ID_W'($urandom_range(0, span))
                                               : ID_W'($urandom);
            style = (style_sel == 1 && $urandom_range(0, 9) < 7) ? 1 :
                    ($urandom_range(0, 9) == 0 ? 2 : 0);
            push_item(op, slot, rand_coord(style), rand_coord(style));
            if (op == ptns_pkg::OP_ADD) hw_est++;
            if (op == ptns_pkg::OP_CLEAR) hw_est = 0;
            if (op <= ptns_pkg::OP_CLEAR) n_random++;
         end
      end

      // hold reset, then release it at a clock edge
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      // anything arriving now is unpredicted and gets flagged by the monitor
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
